// ===== rtl/uhcb_pkg.sv =====
// Shared types, constants and one's-complement helpers for the UDP/IP header builder.
package uhcb_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_IP_VERSION    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_ADDR_HI   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_ADDR_LO   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_ADDR_HI   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_ADDR_LO   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PORT_PAIR     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HOP_AND_CLASS = 3'd6;

  localparam logic [15:0] HOP_AND_CLASS_RST = 16'h4000;

  // Protocol constants
  localparam logic [7:0]  UDP_PROTO    = 8'd17;
  localparam logic [7:0]  IPV4_VER_IHL = 8'h45;
  localparam logic [31:0] IPV6_WORD0   = 32'h6000_0000;
  localparam logic [8:0]  COUNT_MAX    = 9'h1ff;
  localparam logic [9:0]  UDP_HDR_LEN  = 10'd8;
  localparam logic [16:0] IPV4_HDR_LEN = 17'd20;
  localparam logic [16:0] IPV6_HDR_LEN = 17'd40;

  // Back-end step limits: checksum words and header words per framing
  localparam logic [3:0] V4_SUM_LAST  = 4'd4;
  localparam logic [3:0] V6_SUM_LAST  = 4'd10;
  localparam logic [3:0] V4_WORD_LAST = 4'd6;
  localparam logic [3:0] V6_WORD_LAST = 4'd11;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        ip_version;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [31:0] port_pair;
    logic [15:0] hop_and_class;
  } cfg_t;

  // One finished datagram as seen by the back end
  typedef struct packed {
    logic        err;
    logic [8:0]  count;
    logic [15:0] sum;
  } desc_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_EMIT
  } back_state_t;

  // 16-bit one's-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Fold both halves of a 32-bit word into the sum
  function automatic logic [15:0] add32(input logic [15:0] acc, input logic [31:0] w);
    logic [15:0] t;
    t = oc_add(acc, w[31:16]);
    return oc_add(t, w[15:0]);
  endfunction

endpackage

// ===== rtl/uhcb_front.sv =====
// Front end: takes payload bytes, keeps the running sum and count, queues finished datagrams.
module uhcb_front #(
  parameter int MAX_DATAGRAM_BYTES = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  uhcb_pkg::cfg_t  cfg,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  input  logic            q_full,
  output logic            push,
  output uhcb_pkg::desc_t push_desc
);

  logic [15:0] running_sum;
  logic [8:0]  payload_count;
  logic        odd_phase;
  logic [7:0]  pending_high;
  logic        too_long;

  logic        accept;
  logic        sat;
  logic [8:0]  count_next;
  logic        too_long_next;
  logic [15:0] pair_word;
  logic [15:0] sum_next;
  logic [16:0] hdr_len;
  logic [16:0] total;

  // Classify the byte and work out the datagram state after it
  always_comb begin
    s_tready      = !q_full;
    accept        = s_tvalid && s_tready;
    sat           = (payload_count == uhcb_pkg::COUNT_MAX);
    count_next    = sat ? payload_count : payload_count + 9'd1;
    too_long_next = too_long || sat;
    // A trailing odd byte is padded as the high byte
    pair_word     = odd_phase ? {pending_high, s_tdata} : {s_tdata, 8'h00};
    sum_next      = (odd_phase || s_tlast) ? uhcb_pkg::oc_add(running_sum, pair_word)
                                           : running_sum;
    hdr_len       = cfg.ip_version ? uhcb_pkg::IPV6_HDR_LEN : uhcb_pkg::IPV4_HDR_LEN;
    total         = hdr_len + 17'(uhcb_pkg::UDP_HDR_LEN) + 17'(count_next);
    push          = accept && s_tlast;
    push_desc.sum   = sum_next;
    push_desc.count = count_next;
    push_desc.err   = too_long_next || (total > 17'(MAX_DATAGRAM_BYTES));
  end

  // Advance the datagram state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      payload_count <= '0;
      odd_phase     <= 1'b0;
      pending_high  <= '0;
      too_long      <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        running_sum   <= '0;
        payload_count <= '0;
        odd_phase     <= 1'b0;
        pending_high  <= '0;
        too_long      <= 1'b0;
      end else begin
        running_sum   <= sum_next;
        payload_count <= count_next;
        too_long      <= too_long_next;
        odd_phase     <= !odd_phase;
        pending_high  <= odd_phase ? 8'h00 : s_tdata;
      end
    end
  end

endmodule

// ===== rtl/uhcb_queue.sv =====
// Short queue of finished datagram descriptors between front and back.
module uhcb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  uhcb_pkg::desc_t push_desc,
  output logic            full,
  output logic            q_valid,
  output uhcb_pkg::desc_t q_desc,
  input  logic            pop
);

  uhcb_pkg::desc_t                   entries [uhcb_pkg::QUEUE_DEPTH];
  logic [uhcb_pkg::QPTR_W-1:0]       wr_ptr;
  logic [uhcb_pkg::QPTR_W-1:0]       rd_ptr;
  logic [uhcb_pkg::QPTR_W:0]         fill;

  always_comb begin
    full    = (fill == (uhcb_pkg::QPTR_W + 1)'(uhcb_pkg::QUEUE_DEPTH));
    q_valid = (fill != '0);
    q_desc  = entries[rd_ptr];
  end

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/uhcb_back.sv =====
// Back end: folds the pseudo header into the checksum and sends the header words.
module uhcb_back (
  input  logic            clk,
  input  logic            rst,
  input  uhcb_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  uhcb_pkg::desc_t q_desc,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata,
  output logic            m_tlast,
  output logic            m_tuser
);

  uhcb_pkg::back_state_t state, state_next;

  logic [15:0] acc;
  logic [9:0]  ulen;
  logic        err;
  logic [3:0]  step;

  logic        out_free;
  logic        sum_en;
  logic        emit;
  logic        emit_last;
  logic [3:0]  sum_last;
  logic [3:0]  word_last;
  logic [15:0] udp_len;
  logic [15:0] csum;
  logic [15:0] total;
  logic [31:0] sum_word;
  logic [31:0] hdr_word;

  // Per-datagram values derived from the registers
  always_comb begin
    sum_last  = cfg.ip_version ? uhcb_pkg::V6_SUM_LAST : uhcb_pkg::V4_SUM_LAST;
    word_last = cfg.ip_version ? uhcb_pkg::V6_WORD_LAST : uhcb_pkg::V4_WORD_LAST;
    udp_len   = 16'(ulen);
    total     = udp_len + 16'(uhcb_pkg::IPV4_HDR_LEN);
    csum      = ~acc;
    if (csum == 16'h0000) begin
      csum = 16'hffff;
    end
  end

  // Pick the pseudo header word for this checksum step
  always_comb begin
    sum_word = 32'h0;
    if (cfg.ip_version) begin
      case (step)
        4'd0:    sum_word = cfg.src_addr_hi[63:32];
        4'd1:    sum_word = cfg.src_addr_hi[31:0];
        4'd2:    sum_word = cfg.src_addr_lo[63:32];
        4'd3:    sum_word = cfg.src_addr_lo[31:0];
        4'd4:    sum_word = cfg.dst_addr_hi[63:32];
        4'd5:    sum_word = cfg.dst_addr_hi[31:0];
        4'd6:    sum_word = cfg.dst_addr_lo[63:32];
        4'd7:    sum_word = cfg.dst_addr_lo[31:0];
        4'd8:    sum_word = cfg.port_pair;
        4'd9:    sum_word = {udp_len, udp_len};
        default: sum_word = {24'h0, uhcb_pkg::UDP_PROTO};
      endcase
    end else begin
      case (step)
        4'd0:    sum_word = cfg.src_addr_lo[31:0];
        4'd1:    sum_word = cfg.dst_addr_lo[31:0];
        4'd2:    sum_word = cfg.port_pair;
        4'd3:    sum_word = {udp_len, udp_len};
        default: sum_word = {24'h0, uhcb_pkg::UDP_PROTO};
      endcase
    end
  end

  // Pick the header word for this send step
  always_comb begin
    hdr_word = 32'h0;
    if (err) begin
      hdr_word = 32'h0;
    end else if (cfg.ip_version) begin
      case (step)
        4'd0:    hdr_word = uhcb_pkg::IPV6_WORD0;
        4'd1:    hdr_word = {udp_len, uhcb_pkg::UDP_PROTO, cfg.hop_and_class[15:8]};
        4'd2:    hdr_word = cfg.src_addr_hi[63:32];
        4'd3:    hdr_word = cfg.src_addr_hi[31:0];
        4'd4:    hdr_word = cfg.src_addr_lo[63:32];
        4'd5:    hdr_word = cfg.src_addr_lo[31:0];
        4'd6:    hdr_word = cfg.dst_addr_hi[63:32];
        4'd7:    hdr_word = cfg.dst_addr_hi[31:0];
        4'd8:    hdr_word = cfg.dst_addr_lo[63:32];
        4'd9:    hdr_word = cfg.dst_addr_lo[31:0];
        4'd10:   hdr_word = cfg.port_pair;
        default: hdr_word = {udp_len, csum};
      endcase
    end else begin
      case (step)
        4'd0:    hdr_word = {uhcb_pkg::IPV4_VER_IHL, cfg.hop_and_class[7:0], total};
        4'd1:    hdr_word = 32'h0;
        4'd2:    hdr_word = {cfg.hop_and_class[15:8], uhcb_pkg::UDP_PROTO, 16'h0};
        4'd3:    hdr_word = cfg.src_addr_lo[31:0];
        4'd4:    hdr_word = cfg.dst_addr_lo[31:0];
        4'd5:    hdr_word = cfg.port_pair;
        default: hdr_word = {udp_len, csum};
      endcase
    end
  end

  // Next state and step controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    sum_en     = 1'b0;
    emit       = 1'b0;
    out_free   = !m_tvalid || m_tready;
    emit_last  = err || (step == word_last);
    unique case (state)
      uhcb_pkg::B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = q_desc.err ? uhcb_pkg::B_EMIT : uhcb_pkg::B_SUM;
        end
      end
      uhcb_pkg::B_SUM: begin
        sum_en = 1'b1;
        if (step == sum_last) begin
          state_next = uhcb_pkg::B_EMIT;
        end
      end
      uhcb_pkg::B_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (emit_last) begin
            state_next = uhcb_pkg::B_IDLE;
          end
        end
      end
      default: state_next = uhcb_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uhcb_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load a descriptor, fold one word per cycle, step through the header
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (pop) begin
      step <= '0;
    end else if (sum_en) begin
      step <= (step == sum_last) ? 4'd0 : step + 4'd1;
    end else if (emit) begin
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc  <= q_desc.sum;
      ulen <= uhcb_pkg::UDP_HDR_LEN + 10'(q_desc.count);
      err  <= q_desc.err;
    end else if (sum_en) begin
      acc  <= uhcb_pkg::add32(acc, sum_word);
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= hdr_word;
      m_tlast <= emit_last;
      m_tuser <= err;
    end
  end

endmodule

// ===== rtl/udp_ip_header_checksum_builder_core.sv =====
// Top level of the UDP/IP header builder: configuration registers, front, queue and back.
//
//  channel   direction  fields
//  s_*       in         s_tdata[7:0] payload byte, s_tlast final byte of the datagram
//  m_*       out        m_tdata[31:0] header word, m_tlast final word, m_tuser status
//  cfg_*     in         cfg_index selects register, cfg_data holds the value
//
// Payload bytes are taken one per cycle while the two-entry descriptor queue has room.
// Per datagram the back end loads a descriptor, folds 5 (IPv4) or 11 (IPv6) 32-bit words
// into the checksum, one per cycle, then sends 7 or 12 header words; an error sends one
// zero word. The front end stalls only while the descriptor queue is full.
// Reset is synchronous and clears all control state; no clearing pass is needed.
module udp_ip_header_checksum_builder_core #(
  parameter int MAX_DATAGRAM_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] header_word
  output logic        m_tlast,
  output logic        m_tuser,   // [0] status
  input  logic        cfg_wr_en,
  input  logic [uhcb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  uhcb_pkg::cfg_t  cfg;
  uhcb_pkg::desc_t push_desc;
  uhcb_pkg::desc_t q_desc;
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ip_version    <= 1'b0;
      cfg.src_addr_hi   <= '0;
      cfg.src_addr_lo   <= '0;
      cfg.dst_addr_hi   <= '0;
      cfg.dst_addr_lo   <= '0;
      cfg.port_pair     <= '0;
      cfg.hop_and_class <= uhcb_pkg::HOP_AND_CLASS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        uhcb_pkg::REG_IP_VERSION:    cfg.ip_version    <= cfg_data[0];
        uhcb_pkg::REG_SRC_ADDR_HI:   cfg.src_addr_hi   <= cfg_data;
        uhcb_pkg::REG_SRC_ADDR_LO:   cfg.src_addr_lo   <= cfg_data;
        uhcb_pkg::REG_DST_ADDR_HI:   cfg.dst_addr_hi   <= cfg_data;
        uhcb_pkg::REG_DST_ADDR_LO:   cfg.dst_addr_lo   <= cfg_data;
        uhcb_pkg::REG_PORT_PAIR:     cfg.port_pair     <= cfg_data[31:0];
        uhcb_pkg::REG_HOP_AND_CLASS: cfg.hop_and_class <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  uhcb_front #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_desc(push_desc)
  );

  uhcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_desc   (q_desc),
    .pop      (pop)
  );

  uhcb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_desc  (q_desc),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  // An error result is a single zero word that closes the datagram
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 32'h0))
    else $error("error result without last marker or with data");

  // A datagram is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("descriptor pushed into full queue");

  // The back end only pops a descriptor that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("descriptor popped from empty queue");

  // Nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

// ===== sim/tb_udp_ip_header_checksum_builder_core.sv =====
// Self-checking testbench for the UDP/IP header checksum builder core.
module tb_udp_ip_header_checksum_builder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES      = 256;
  localparam int IPV4_HDR_BYTES = 20;
  localparam int IPV6_HDR_BYTES = 40;
  localparam int UDP_HDR_BYTES  = 8;
  localparam int COUNT_CEILING  = 511;
  localparam int RANDOM_BYTES   = 32;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int CYCLE_LIMIT    = 400000;

  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [7:0]  V4_VERSION_IHL  = 8'h45;
  localparam logic [31:0] V6_FIRST_WORD   = 32'h6000_0000;
  localparam logic [15:0] ZERO_SUM_CODE   = 16'hffff;
  localparam logic [uhcb_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic [7:0] payload_t[$];

  typedef struct packed {
    logic [31:0] word;
    logic        is_last;
    logic        status;
  } hdr_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [uhcb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Register copies held by the predictor
  logic        cf_ipv6      = 1'b0;
  logic [63:0] cf_src_hi    = '0;
  logic [63:0] cf_src_lo    = '0;
  logic [63:0] cf_dst_hi    = '0;
  logic [63:0] cf_dst_lo    = '0;
  logic [31:0] cf_ports     = '0;
  logic [15:0] cf_hop_class = 16'h4000;

  // Per-datagram state of the predictor
  logic [15:0] dg_sum   = '0;
  logic [8:0]  dg_count = '0;
  logic        dg_odd   = 1'b0;
  logic [7:0]  dg_high  = '0;
  logic        dg_over  = 1'b0;
  logic [15:0] last_checksum = '0;

  hdr_item_t expected_words[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_level = 0;
  int hold_serial = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  udp_ip_header_checksum_builder_core #(
    .MAX_DATAGRAM_BYTES(MAX_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),     // [7:0] data_byte
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),     // [31:0] header_word
    .m_tlast(m_tlast),
    .m_tuser(m_tuser),     // [0] status
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // End-around-carry addition of two 16-bit words
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    int unsigned t;
    t = a + b;
    if (t > 32'hffff) t = t - 32'hffff;
    return t[15:0];
  endfunction

  // Fold a 64-bit value into the sum, most significant word first
  function automatic logic [15:0] ones_add_wide(input logic [15:0] acc, input logic [63:0] v);
    logic [15:0] r;
    r = acc;
    for (int k = 3; k >= 0; k--) r = ones_add(r, v[k*16 +: 16]);
    return r;
  endfunction

  task automatic push_expected(input logic [31:0] w, input logic l, input logic st);
    hdr_item_t e;
    e.word = w;
    e.is_last = l;
    e.status = st;
    expected_words.push_back(e);
  endtask

  // Advance the datagram state by one payload byte; on the final byte queue the header words
  task automatic predict_header_words(input logic [7:0] b, input logic is_last);
    int unsigned hdr_len, udp_len, total;
    logic [15:0] acc, csum;
    logic [7:0]  ttl;
    if (dg_count >= COUNT_CEILING) dg_over = 1'b1;
    else dg_count = dg_count + 9'd1;
    if (dg_odd) begin
      dg_sum = ones_add(dg_sum, {dg_high, b});
      dg_odd = 1'b0;
      dg_high = '0;
    end else begin
      dg_high = b;
      dg_odd = 1'b1;
    end
    if (!is_last) return;

    // pad a trailing odd byte as the high half of a word
    if (dg_odd) dg_sum = ones_add(dg_sum, {dg_high, 8'h00});
    hdr_len = cf_ipv6 ? IPV6_HDR_BYTES : IPV4_HDR_BYTES;
    udp_len = UDP_HDR_BYTES + dg_count;
    total = hdr_len + udp_len;

    if (dg_over || total > MAX_BYTES) begin
      push_expected('0, 1'b1, 1'b1);
    end else begin
      ttl = cf_hop_class[15:8];
      acc = dg_sum;
      if (cf_ipv6) begin
        acc = ones_add_wide(acc, cf_src_hi);
        acc = ones_add_wide(acc, cf_src_lo);
        acc = ones_add_wide(acc, cf_dst_hi);
        acc = ones_add_wide(acc, cf_dst_lo);
      end else begin
        acc = ones_add_wide(acc, {32'h0, cf_src_lo[31:0]});
        acc = ones_add_wide(acc, {32'h0, cf_dst_lo[31:0]});
      end
      acc = ones_add(acc, {8'h00, PROTO_UDP});
      acc = ones_add(acc, udp_len[15:0]);
      acc = ones_add(acc, cf_ports[31:16]);
      acc = ones_add(acc, cf_ports[15:0]);
      acc = ones_add(acc, udp_len[15:0]);
      csum = ~acc;
      if (csum == 16'h0000) csum = ZERO_SUM_CODE;
      last_checksum = csum;

      if (cf_ipv6) begin
        push_expected(V6_FIRST_WORD, 1'b0, 1'b0);
        push_expected({udp_len[15:0], PROTO_UDP, ttl}, 1'b0, 1'b0);
        push_expected(cf_src_hi[63:32], 1'b0, 1'b0);
        push_expected(cf_src_hi[31:0], 1'b0, 1'b0);
        push_expected(cf_src_lo[63:32], 1'b0, 1'b0);
        push_expected(cf_src_lo[31:0], 1'b0, 1'b0);
        push_expected(cf_dst_hi[63:32], 1'b0, 1'b0);
        push_expected(cf_dst_hi[31:0], 1'b0, 1'b0);
        push_expected(cf_dst_lo[63:32], 1'b0, 1'b0);
        push_expected(cf_dst_lo[31:0], 1'b0, 1'b0);
      end else begin
        push_expected({V4_VERSION_IHL, cf_hop_class[7:0], total[15:0]}, 1'b0, 1'b0);
        push_expected('0, 1'b0, 1'b0);
        push_expected({ttl, PROTO_UDP, 16'h0000}, 1'b0, 1'b0);
        push_expected(cf_src_lo[31:0], 1'b0, 1'b0);
        push_expected(cf_dst_lo[31:0], 1'b0, 1'b0);
      end
      push_expected(cf_ports, 1'b0, 1'b0);
      push_expected({udp_len[15:0], csum}, 1'b1, 1'b0);
    end

    // clear for the next datagram
    dg_sum = '0;
    dg_count = '0;
    dg_odd = 1'b0;
    dg_high = '0;
    dg_over = 1'b0;
  endtask

  // Offer one payload byte, with an occasional gap first, and predict once it is taken
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (idle_level != 0 && $urandom_range(1, 8) <= idle_level) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
    predict_header_words(b, is_last);
  endtask

  task automatic send_datagram(input payload_t p);
    for (int i = 0; i < p.size(); i++) send_byte(p[i], i == p.size() - 1);
  endtask

  function automatic payload_t random_payload(input int n);
    payload_t p;
    for (int i = 0; i < n; i++) p.push_back(8'($urandom_range(0, 255)));
    return p;
  endfunction

  // Drop valid, wait for every expected word, then let the back end settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [uhcb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      uhcb_pkg::REG_IP_VERSION:    cf_ipv6 = val[0];
      uhcb_pkg::REG_SRC_ADDR_HI:   cf_src_hi = val;
      uhcb_pkg::REG_SRC_ADDR_LO:   cf_src_lo = val;
      uhcb_pkg::REG_DST_ADDR_HI:   cf_dst_hi = val;
      uhcb_pkg::REG_DST_ADDR_LO:   cf_dst_lo = val;
      uhcb_pkg::REG_PORT_PAIR:     cf_ports = val[31:0];
      uhcb_pkg::REG_HOP_AND_CLASS: cf_hop_class = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_setting(input logic [63:0] ver, input logic [63:0] src_hi,
                               input logic [63:0] src_lo, input logic [63:0] dst_hi,
                               input logic [63:0] dst_lo, input logic [63:0] ports,
                               input logic [63:0] hop);
    wait_drained();
    write_reg(uhcb_pkg::REG_IP_VERSION, ver);
    write_reg(uhcb_pkg::REG_SRC_ADDR_HI, src_hi);
    write_reg(uhcb_pkg::REG_SRC_ADDR_LO, src_lo);
    write_reg(uhcb_pkg::REG_DST_ADDR_HI, dst_hi);
    write_reg(uhcb_pkg::REG_DST_ADDR_LO, dst_lo);
    write_reg(uhcb_pkg::REG_PORT_PAIR, ports);
    write_reg(uhcb_pkg::REG_HOP_AND_CLASS, hop);
  endtask

  function automatic logic [63:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_random_setting();
    wait_drained();
    for (int i = uhcb_pkg::REG_IP_VERSION; i <= uhcb_pkg::REG_HOP_AND_CLASS; i++)
      write_reg((uhcb_pkg::CFG_INDEX_W)'(i), pick_reg_value());
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  // Output side: random stalls, and a long hold-off on request
  always @(posedge clk) begin
    if (hold_serial != hold_seen) begin
      hold_seen = hold_serial;
      hold_left = HOLD_OFF_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_level != 0 && $urandom_range(1, 8) <= idle_level) begin
      stall_left = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  // Compare each accepted header word with the oldest expectation
  always @(posedge clk) begin : check_words
    hdr_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected header word", '0, m_tdata);
      end else begin
        want = expected_words.pop_front();
        if (m_tdata !== want.word) note_mismatch("header_word", want.word, m_tdata);
        if (m_tlast !== want.is_last) note_mismatch("word_last", want.is_last, m_tlast);
        if (m_tuser !== want.status) note_mismatch("status", want.status, m_tuser);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Reset values of the registers, with even and odd payloads
  task automatic test_reset_values();
    payload_t p;
    idle_level = 2;
    p = '{8'h12, 8'h34, 8'h56, 8'h78};
    send_datagram(p);
    p = '{8'hab};
    send_datagram(p);
    wait_drained();
  endtask

  // Each register in both framings; the unused index must change nothing
  task automatic test_register_map();
    payload_t p;
    write_setting(64'h1, 64'h2001_0db8_1122_3344, 64'h5566_7788_c0a8_0101,
                  64'hfe80_0000_0000_0000, 64'h0a0b_0c0d_0a00_0002,
                  64'h1234_5678_abcd_0035, 64'h0000_0000_0000_40b8);
    write_reg(REG_UNUSED, '1);
    p = '{8'hde, 8'had, 8'hbe};
    send_datagram(p);
    wait_drained();
    write_reg(uhcb_pkg::REG_IP_VERSION, 64'hffff_ffff_ffff_fffe);
    write_reg(REG_UNUSED, '0);
    send_datagram(p);
    wait_drained();
  endtask

  // All-ones and all-zero registers and payloads
  task automatic test_field_extremes();
    payload_t p;
    write_setting('0, '1, '1, '1, '1, '1, '1);
    p = '{8'hff, 8'hff, 8'hff};
    send_datagram(p);
    p = '{8'h00};
    send_datagram(p);
    write_setting('1, '1, '1, '1, '1, '1, '1);
    p = '{8'hff, 8'hff};
    send_datagram(p);
    write_setting('0, '0, '0, '0, '0, '0, '0);
    p = '{8'h00, 8'h00};
    send_datagram(p);
    write_setting('1, '0, '0, '0, '0, '0, '0);
    send_datagram(p);
    wait_drained();
  endtask

  // Choose a payload word that cancels the rest of the sum, so the checksum comes out zero
  task automatic test_zero_checksum();
    payload_t p;
    logic [15:0] c0;
    for (int v = 0; v < 2; v++) begin
      write_setting(64'(v), {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
      p = '{8'h00, 8'h00};
      send_datagram(p);
      c0 = last_checksum;
      p = '{c0[15:8], c0[7:0]};
      send_datagram(p);
      wait_drained();
    end
  endtask

  // Largest IPv6 datagram that fits, one byte over, then a short one
  task automatic test_size_limit();
    idle_level = 1;
    write_setting('1, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    send_datagram(random_payload(MAX_BYTES - IPV6_HDR_BYTES - UDP_HDR_BYTES));
    send_datagram(random_payload(MAX_BYTES - IPV6_HDR_BYTES - UDP_HDR_BYTES + 1));
    send_datagram(random_payload(1));
    wait_drained();
  endtask

  // Hold the output off while short datagrams keep coming, so the input stalls
  task automatic test_output_hold_off();
    idle_level = 0;
    hold_serial++;
    for (int i = 0; i < 6; i++) send_datagram(random_payload($urandom_range(1, 3)));
    wait_drained();
  endtask

  // Random settings and lengths, short datagrams only
  task automatic test_random_traffic();
    int sent, dgrams, len;
    sent = 0;
    dgrams = 0;
    while (sent < RANDOM_BYTES) begin
      if (dgrams % 3 == 0) begin
        load_random_setting();
        idle_level = $urandom_range(0, 3);
      end
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(9, 16);
        default: len = $urandom_range(1, 8);
      endcase
      send_datagram(random_payload(len));
      sent += len;
      dgrams++;
    end
    wait_drained();
  endtask

  // Back-to-back traffic with no gaps on either side
  task automatic test_steady_stream();
    load_random_setting();
    idle_level = 0;
    for (int i = 0; i < 4; i++) send_datagram(random_payload($urandom_range(1, 6)));
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_register_map();
    test_field_extremes();
    test_zero_checksum();
    test_size_limit();
    test_output_hold_off();
    test_random_traffic();
    test_steady_stream();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
